// ===== src/mrrc_pkg.sv =====
// Shared types, field layout and helper function of the residue range counter.
`default_nettype none
package mrrc_pkg;

  // Input word layout, packed from the lowest bit up.
  localparam int unsigned MulW   = 31;
  localparam int unsigned ModW   = 30;
  localparam int unsigned BndW   = 32;
  localparam int unsigned MulLsb = 0;
  localparam int unsigned ModLsb = MulLsb + MulW;
  localparam int unsigned CloLsb = ModLsb + ModW;
  localparam int unsigned ChiLsb = CloLsb + BndW;
  localparam int unsigned NloLsb = ChiLsb + BndW;
  localparam int unsigned NhiLsb = NloLsb + BndW;
  localparam int unsigned QryW   = NhiLsb + BndW;
  localparam int unsigned InDataW  = ((QryW + 7) / 8) * 8;
  localparam int unsigned CntW     = 64;

  typedef logic [CntW-1:0] word_t;

  // Sequencer states of the back end.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P_INIT,
    ST_P_R,
    ST_P_Q,
    ST_P_ACC,
    ST_P_N,
    ST_P_CHK1,
    ST_P_TOP1,
    ST_P_MQ,
    ST_P_CHK2,
    ST_P_TOP2,
    ST_P_END,
    ST_L_INIT,
    ST_L_LOOP,
    ST_L_DK,
    ST_L_DF,
    ST_L_DE,
    ST_L_M1,
    ST_L_M2,
    ST_L_M3,
    ST_L_M4,
    ST_L_RET,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quot;
    word_t rem;
  } div_rsp_t;

  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

  typedef struct packed {
    word_t q;
    word_t r;
  } fdiv_t;

  // Turns a magnitude division into a floor division with a nonnegative remainder.
  function automatic fdiv_t floor_fix(input logic neg, input word_t q0, input word_t r0,
                                      input word_t m);
    fdiv_t res;
    res.q = neg ? (~q0 + 64'd1) : q0;
    res.r = neg ? (~r0 + 64'd1) : r0;
    if (neg && (r0 != '0)) begin
      res.q = res.q - 64'd1;
      res.r = res.r + m;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== src/mrrc_fifo.sv =====
// Short query queue between the input port and the sequencer.
`default_nettype none
module mrrc_fifo #(
  parameter int unsigned Depth = 4,
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [Width-1:0]      pop_data_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/mrrc_div.sv =====
// Radix-2 restoring divider for 64-bit unsigned operands, one quotient bit a cycle.
`default_nettype none
module mrrc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mrrc_pkg::div_req_t req_i,
  output mrrc_pkg::div_rsp_t     rsp_o
);
  mrrc_pkg::word_t quo_q, rem_q, dsr_q;
  logic [5:0]      cnt_q;
  logic            busy_q, done_q;
  logic [64:0]     trial, diff;
  logic            take;

  // One shift and trial subtraction.
  always_comb begin
    trial = {rem_q, quo_q[63]};
    diff  = trial - {1'b0, dsr_q};
    take  = !diff[64];
  end

  // Operand and partial-result registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], take};
      rem_q <= take ? diff[63:0] : trial[63:0];
    end
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;
endmodule
`default_nettype wire

// ===== src/mrrc_mul.sv =====
// Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
`default_nettype none
module mrrc_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mrrc_pkg::mul_req_t req_i,
  output mrrc_pkg::mul_rsp_t     rsp_o
);
  mrrc_pkg::word_t a_q, b_q, acc_q, pp;
  logic [1:0]      ph_q;
  logic            busy_q, done_q;
  logic [31:0]     x, y;

  // Partial product for the current phase.
  always_comb begin
    case (ph_q)
      2'd0:    begin x = a_q[31:0];  y = b_q[31:0];  end
      2'd1:    begin x = a_q[31:0];  y = b_q[63:32]; end
      default: begin x = a_q[63:32]; y = b_q[31:0];  end
    endcase
    pp = 64'(x) * 64'(y);
  end

  // Operands and accumulator.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.op_a;
      b_q <= req_i.op_b;
    end else if (busy_q) begin
      if (ph_q == 2'd0) begin
        acc_q <= pp;
      end else begin
        acc_q <= acc_q + {pp[31:0], 32'd0};
      end
    end
  end

  // Phase control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;
endmodule
`default_nettype wire

// ===== src/mrrc_core.sv =====
// Back end: sequencer for prefix and lattice counts, shared divider and multiplier.
`default_nettype none
module mrrc_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        qry_valid_i,
  output logic                             qry_ready_o,
  input  wire logic [mrrc_pkg::QryW-1:0]   qry_data_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output mrrc_pkg::word_t                  res_data_o
);
  mrrc_pkg::st_e state_q, state_d;

  // Query fields.
  logic [mrrc_pkg::MulW-1:0] qa_q;
  logic [mrrc_pkg::ModW-1:0] qm_q;
  logic [mrrc_pkg::BndW-1:0] qclo_q, qchi_q, qnlo_q, qnhi_q;
  mrrc_pkg::word_t a64, m64, clo64, chi64, nlo64, nhi64;

  // Prefix and lattice working registers.
  mrrc_pkg::word_t res_q, pc_q, pn_q, pr_q, pq_q, pcm_q, pqn_q, pnm_q, pb_q;
  mrrc_pkg::word_t pacc_q, ptop_q, pl1_q, pdiff_q;
  mrrc_pkg::word_t la_q, lb_q, lc_q, lk_q, ll_q, lf_q, lrem_q, le_q, lg_q;
  mrrc_pkg::word_t lt1_q, ltr_q, lacc_q;
  logic [1:0]      pi_q, li_q;
  logic            pend_q;
  logic            out_valid_q;
  mrrc_pkg::word_t out_data_q;

  mrrc_pkg::div_req_t div_req;
  mrrc_pkg::div_rsp_t div_rsp;
  mrrc_pkg::mul_req_t mul_req;
  mrrc_pkg::mul_rsp_t mul_rsp;
  mrrc_pkg::word_t    div_x, sel_c, sel_n;
  logic               div_neg, is_div, is_mul, out_free;
  mrrc_pkg::fdiv_t    ff;

  assign a64   = {{33{qa_q[mrrc_pkg::MulW-1]}}, qa_q};
  assign m64   = {34'd0, qm_q};
  assign clo64 = {{32{qclo_q[31]}}, qclo_q};
  assign chi64 = {{32{qchi_q[31]}}, qchi_q};
  assign nlo64 = {{32{qnlo_q[31]}}, qnlo_q};
  assign nhi64 = {{32{qnhi_q[31]}}, qnhi_q};
  assign out_free = !out_valid_q || res_ready_i;

  // Bounds of the current prefix count: high/high, high/low, low/high, low/low.
  always_comb begin
    sel_c = pi_q[1] ? clo64 : chi64;
    sel_n = pi_q[0] ? nlo64 : nhi64;
  end

  mrrc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));
  mrrc_mul u_mul (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(mul_req), .rsp_o(mul_rsp));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mrrc_pkg::ST_IDLE:   if (qry_valid_i) begin
        state_d = (qry_data_i[mrrc_pkg::ModLsb +: mrrc_pkg::ModW] == '0)
                  ? mrrc_pkg::ST_DONE : mrrc_pkg::ST_P_INIT;
      end
      mrrc_pkg::ST_P_INIT: state_d = (sel_n == '0) ? mrrc_pkg::ST_P_END : mrrc_pkg::ST_P_R;
      mrrc_pkg::ST_P_R:    if (div_rsp.done) state_d = mrrc_pkg::ST_P_Q;
      mrrc_pkg::ST_P_Q:    if (div_rsp.done) state_d = mrrc_pkg::ST_P_ACC;
      mrrc_pkg::ST_P_ACC:  if (mul_rsp.done) state_d = mrrc_pkg::ST_P_N;
      mrrc_pkg::ST_P_N:    if (div_rsp.done) state_d = mrrc_pkg::ST_P_CHK1;
      mrrc_pkg::ST_P_CHK1: state_d = (pqn_q == '0) ? mrrc_pkg::ST_P_CHK2
                                                    : mrrc_pkg::ST_P_TOP1;
      mrrc_pkg::ST_P_TOP1: if (mul_rsp.done) state_d = mrrc_pkg::ST_L_INIT;
      mrrc_pkg::ST_P_MQ:   if (mul_rsp.done) state_d = mrrc_pkg::ST_P_CHK2;
      mrrc_pkg::ST_P_CHK2: state_d = (pnm_q == '0) ? mrrc_pkg::ST_P_END
                                                    : mrrc_pkg::ST_P_TOP2;
      mrrc_pkg::ST_P_TOP2: if (mul_rsp.done) state_d = mrrc_pkg::ST_L_INIT;
      mrrc_pkg::ST_P_END:  state_d = (pi_q == 2'd3) ? mrrc_pkg::ST_DONE
                                                     : mrrc_pkg::ST_P_INIT;
      mrrc_pkg::ST_L_INIT: state_d = lc_q[63] ? mrrc_pkg::ST_L_RET : mrrc_pkg::ST_L_LOOP;
      mrrc_pkg::ST_L_LOOP: state_d = (lc_q[63] || (la_q == '0)) ? mrrc_pkg::ST_L_RET
                                                                   : mrrc_pkg::ST_L_DK;
      mrrc_pkg::ST_L_DK:   if (div_rsp.done) state_d = mrrc_pkg::ST_L_DF;
      mrrc_pkg::ST_L_DF:   if (div_rsp.done) state_d = mrrc_pkg::ST_L_DE;
      mrrc_pkg::ST_L_DE:   if (div_rsp.done) state_d = mrrc_pkg::ST_L_M1;
      mrrc_pkg::ST_L_M1:   if (mul_rsp.done) state_d = mrrc_pkg::ST_L_M2;
      mrrc_pkg::ST_L_M2:   if (mul_rsp.done) state_d = mrrc_pkg::ST_L_M3;
      mrrc_pkg::ST_L_M3:   if (mul_rsp.done) state_d = mrrc_pkg::ST_L_M4;
      mrrc_pkg::ST_L_M4:   if (mul_rsp.done) state_d = mrrc_pkg::ST_L_LOOP;
      mrrc_pkg::ST_L_RET: begin
        case (li_q)
          2'd1:    state_d = mrrc_pkg::ST_P_MQ;
          2'd3:    state_d = mrrc_pkg::ST_P_END;
          default: state_d = mrrc_pkg::ST_L_INIT;
        endcase
      end
      mrrc_pkg::ST_DONE:   if (out_free) state_d = mrrc_pkg::ST_IDLE;
      default:             state_d = mrrc_pkg::ST_IDLE;
    endcase
  end

  // Outputs: operand selection for the arithmetic units.
  always_comb begin
    is_div = 1'b0;
    is_mul = 1'b0;
    div_x  = '0;
    div_neg = 1'b0;
    div_req.divisor = m64;
    mul_req.op_a = '0;
    mul_req.op_b = '0;
    qry_ready_o = (state_q == mrrc_pkg::ST_IDLE);
    unique case (state_q)
      mrrc_pkg::ST_P_R: begin is_div = 1'b1; div_x = a64;  div_neg = a64[63]; end
      mrrc_pkg::ST_P_Q: begin is_div = 1'b1; div_x = pc_q; div_neg = pc_q[63]; end
      mrrc_pkg::ST_P_N: begin is_div = 1'b1; div_x = pn_q; div_neg = pn_q[63]; end
      mrrc_pkg::ST_L_DK: begin is_div = 1'b1; div_x = lb_q;   div_req.divisor = la_q; end
      mrrc_pkg::ST_L_DF: begin is_div = 1'b1; div_x = lc_q;   div_req.divisor = lb_q; end
      mrrc_pkg::ST_L_DE: begin is_div = 1'b1; div_x = lrem_q; div_req.divisor = la_q; end
      mrrc_pkg::ST_P_ACC: begin
        is_mul = 1'b1; mul_req.op_a = pq_q; mul_req.op_b = pn_q;
      end
      mrrc_pkg::ST_P_TOP1: begin
        is_mul = 1'b1; mul_req.op_a = pb_q; mul_req.op_b = m64 - 64'd1;
      end
      mrrc_pkg::ST_P_MQ: begin
        is_mul = 1'b1; mul_req.op_a = pqn_q; mul_req.op_b = pdiff_q;
      end
      mrrc_pkg::ST_P_TOP2: begin
        is_mul = 1'b1; mul_req.op_a = pb_q; mul_req.op_b = pnm_q - 64'd1;
      end
      mrrc_pkg::ST_L_M1: begin
        is_mul = 1'b1;
        mul_req.op_a = lf_q + 64'd1;
        mul_req.op_b = le_q + 64'd1;
      end
      mrrc_pkg::ST_L_M2: begin
        // Triangle number f(f+1)/2, halving whichever factor is even.
        is_mul = 1'b1;
        if (!lf_q[0]) begin
          mul_req.op_a = {1'b0, lf_q[63:1]};
          mul_req.op_b = lf_q + 64'd1;
        end else begin
          mul_req.op_a = lf_q;
          mul_req.op_b = (lf_q + 64'd1) >> 1;
        end
      end
      mrrc_pkg::ST_L_M3: begin is_mul = 1'b1; mul_req.op_a = ltr_q; mul_req.op_b = lk_q; end
      mrrc_pkg::ST_L_M4: begin is_mul = 1'b1; mul_req.op_a = lf_q;  mul_req.op_b = ll_q; end
      default:   begin end
    endcase
    div_req.start    = is_div && !pend_q;
    div_req.dividend = div_neg ? (~div_x + 64'd1) : div_x;
    mul_req.start    = is_mul && !pend_q;
    ff = mrrc_pkg::floor_fix(div_neg, div_rsp.quot, div_rsp.rem, m64);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mrrc_pkg::ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pi_q        <= '0;
      li_q        <= '0;
    end else begin
      state_q <= state_d;
      if (div_req.start || mul_req.start) begin
        pend_q <= 1'b1;
      end else if (div_rsp.done || mul_rsp.done) begin
        pend_q <= 1'b0;
      end
      // A finished count is loaded once the output word is free.
      if ((state_q == mrrc_pkg::ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        mrrc_pkg::ST_IDLE:   pi_q <= '0;
        mrrc_pkg::ST_P_END:  pi_q <= pi_q + 2'd1;
        mrrc_pkg::ST_P_TOP1: li_q <= 2'd0;
        mrrc_pkg::ST_P_TOP2: li_q <= 2'd2;
        mrrc_pkg::ST_L_RET:  if (!li_q[0]) li_q <= li_q + 2'd1;
        default:             begin end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      mrrc_pkg::ST_IDLE: if (qry_valid_i) begin
        qa_q   <= qry_data_i[mrrc_pkg::MulLsb +: mrrc_pkg::MulW];
        qm_q   <= qry_data_i[mrrc_pkg::ModLsb +: mrrc_pkg::ModW];
        qclo_q <= qry_data_i[mrrc_pkg::CloLsb +: mrrc_pkg::BndW];
        qchi_q <= qry_data_i[mrrc_pkg::ChiLsb +: mrrc_pkg::BndW];
        qnlo_q <= qry_data_i[mrrc_pkg::NloLsb +: mrrc_pkg::BndW];
        qnhi_q <= qry_data_i[mrrc_pkg::NhiLsb +: mrrc_pkg::BndW];
        res_q  <= '0;
      end
      mrrc_pkg::ST_P_INIT: begin
        pc_q   <= sel_c;
        pn_q   <= sel_n;
        pacc_q <= '0;
      end
      mrrc_pkg::ST_P_R:   if (div_rsp.done) pr_q <= ff.r;
      mrrc_pkg::ST_P_Q:   if (div_rsp.done) begin pq_q <= ff.q; pcm_q <= ff.r; end
      mrrc_pkg::ST_P_ACC: if (mul_rsp.done) pacc_q <= mul_rsp.prod;
      mrrc_pkg::ST_P_N:   if (div_rsp.done) begin
        pqn_q <= ff.q;
        pnm_q <= ff.r;
        pb_q  <= pr_q + m64;
      end
      mrrc_pkg::ST_P_TOP1, mrrc_pkg::ST_P_TOP2: if (mul_rsp.done) begin
        ptop_q <= mul_rsp.prod;
        la_q   <= m64;
        lb_q   <= pb_q;
        lc_q   <= mul_rsp.prod;
      end
      mrrc_pkg::ST_P_MQ:  if (mul_rsp.done) pacc_q <= pacc_q + mul_rsp.prod;
      mrrc_pkg::ST_P_END: begin
        if (pi_q == 2'd0 || pi_q == 2'd3) begin
          res_q <= res_q + pacc_q;
        end else begin
          res_q <= res_q - pacc_q;
        end
      end
      mrrc_pkg::ST_L_INIT: begin
        lacc_q <= '0;
        if (la_q > lb_q) begin
          la_q <= lb_q;
          lb_q <= la_q;
        end
      end
      mrrc_pkg::ST_L_DK: if (div_rsp.done) begin
        lk_q <= div_rsp.quot; ll_q <= div_rsp.rem;
      end
      mrrc_pkg::ST_L_DF: if (div_rsp.done) begin
        lf_q <= div_rsp.quot; lrem_q <= div_rsp.rem;
      end
      mrrc_pkg::ST_L_DE: if (div_rsp.done) begin
        le_q <= div_rsp.quot; lg_q <= div_rsp.rem;
      end
      mrrc_pkg::ST_L_M1: if (mul_rsp.done) lt1_q <= mul_rsp.prod;
      mrrc_pkg::ST_L_M2: if (mul_rsp.done) ltr_q <= mul_rsp.prod;
      mrrc_pkg::ST_L_M3: if (mul_rsp.done) lacc_q <= lacc_q + lt1_q + mul_rsp.prod;
      mrrc_pkg::ST_L_M4: if (mul_rsp.done) begin
        lc_q <= mul_rsp.prod - la_q + lg_q;
        lb_q <= la_q;
        la_q <= ll_q;
      end
      mrrc_pkg::ST_L_RET: begin
        // Second count of a pair reuses the same top less the residue bound.
        if (!li_q[0]) begin
          pl1_q <= lacc_q;
          la_q  <= m64;
          lb_q  <= pb_q;
          lc_q  <= ptop_q - pcm_q;
        end else if (li_q == 2'd1) begin
          pdiff_q <= pl1_q - lacc_q;
        end else begin
          pacc_q <= pacc_q + pl1_q - lacc_q;
        end
      end
      mrrc_pkg::ST_DONE: if (out_free) out_data_q <= res_q;
      default: begin end
    endcase
  end

  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_data_q;
endmodule
`default_nettype wire

// ===== src/modular_residue_range_count.sv =====
// Work per query: four prefix counts, H lattice counts (up to 16) and L Euclid rounds in
// total; a round is three divisions on the shared divider, four multiplies and one loop
// check.
// Throughput: one query at a time in the sequencer; a queue of FIFO_DEPTH queries in front
// and an output register behind let both ports keep moving while a query is worked on.
// Reset: asynchronous, active low; clears the queue, sequencer and output valid.
`default_nettype none
module modular_residue_range_count #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // multiplier[30:0], modulus[60:31], residue_low[92:61], residue_high[124:93],
  // index_low[156:125], index_high[188:157], zero fill above
  input  wire logic [mrrc_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // match_count[63:0]
  output logic [mrrc_pkg::CntW-1:0]           m_axis_tdata_o
);
  logic                      qry_valid, qry_ready;
  logic [mrrc_pkg::QryW-1:0] qry_data;

  // Front end: queue of accepted query words.
  mrrc_fifo #(
    .Depth(FIFO_DEPTH),
    .Width(mrrc_pkg::QryW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_ready_o (s_axis_tready_o),
    .push_data_i  (s_axis_tdata_i[mrrc_pkg::QryW-1:0]),
    .pop_valid_o  (qry_valid),
    .pop_ready_i  (qry_ready),
    .pop_data_o   (qry_data)
  );

  // Back end: counting sequencer.
  mrrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qry_valid_i (qry_valid),
    .qry_ready_o (qry_ready),
    .qry_data_i  (qry_data),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_data_o  (m_axis_tdata_o)
  );
endmodule
`default_nettype wire
